// File: hdl/olm_pkg.sv
// Shared types and constants for the octave band level meter.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package olm_pkg;

	// Field widths
	localparam int IN_W      = 28;
	localparam int MAG_W     = 20;
	localparam int BAND_W    = 4;
	localparam int BAR_W     = 4;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Quotient bits of the range divide: a grown range stays below twice the old one
	localparam int QR = MAG_W + 1;

	localparam logic [MAG_W-1:0] MAG_MAX = '1;

	// Magnitude estimate weights, Q0.16
	localparam logic [15:0] ALPHA_Q16 = 16'd62942;
	localparam logic [15:0] BETA_Q16  = 16'd26070;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FLOOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_SPACING = 2'd2;

	// Reset values
	localparam logic [CFG_W-1:0] NOISE_FLOOR_RST = 16'd328;
	localparam logic [CFG_W-1:0] RANGE_FLOOR_RST = 16'd4260;
	localparam logic [CFG_W-1:0] BIN_SPACING_RST = 16'd600;
	localparam logic [MAG_W-1:0] AUTO_RANGE_RST  = 20'd4260;

	// Parameter defaults
	localparam int BAND_COUNT_DEF = 9;
	localparam int BAR_ROWS_DEF   = 15;
	localparam int FFT_SIZE_DEF   = 512;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul_hi;
		logic mul_lo;
		logic freq;
		logic eval;
		logic fin_src;
		logic bar_prep;
		logic bar_chk;
		logic bar_take;
		logic rng_prep;
		logic rng_start;
		logic rng_take;
		logic emit;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic close;
		logic frame_end;
		logic last;
		logic bar_direct;
		logic bar_ovf;
		logic rng_keep;
		logic div_done;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: hdl/olm_div.sv
// Restoring divider, one quotient bit per cycle, for bar heights.
// Depends on olm_pkg for the magnitude width and the quotient width.
`default_nettype none

module olm_div #(
	parameter int NUM_W = 26,
	parameter int QB    = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NUM_W-1:0]          num,
	input  logic [olm_pkg::MAG_W-1:0] den,
	output logic                      busy,
	output logic                      done,
	output logic [olm_pkg::QR-1:0]    quo
);
	import olm_pkg::*;

	localparam int CW    = MAG_W + QR - 1;
	localparam int CNT_W = $clog2(QR + 1);

	logic [NUM_W-1:0] rem_q;
	logic [CW-1:0]    dsh_q;
	logic [QR-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;

	// Trial subtract against the shifted divisor
	assign ge = CW'(rem_q) >= dsh_q;

	// Count steps, flag completion for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(QB);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift the divisor down and collect quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= CW'(den) << (QB - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[NUM_W-1:0];
			end
			quo_q <= {quo_q[QR-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// File: hdl/olm_ctrl.sv
// Sequencer for the level meter: steps each bin through magnitude, band and range work.
// Depends on olm_pkg for the command and status structs.
`default_nettype none

module olm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  olm_pkg::dp_sts_t    sts,
	output olm_pkg::ctrl_cmd_t  cmd
);
	import olm_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_MUL_HI  = 4'd1;
	localparam logic [3:0] ST_MUL_LO  = 4'd2;
	localparam logic [3:0] ST_FREQ    = 4'd3;
	localparam logic [3:0] ST_EVAL    = 4'd4;
	localparam logic [3:0] ST_FE      = 4'd5;
	localparam logic [3:0] ST_BAR     = 4'd6;
	localparam logic [3:0] ST_BAR_CHK = 4'd7;
	localparam logic [3:0] ST_DIV     = 4'd8;
	localparam logic [3:0] ST_RNG     = 4'd9;
	localparam logic [3:0] ST_RNG_GO  = 4'd10;
	localparam logic [3:0] ST_RNG_DIV = 4'd11;
	localparam logic [3:0] ST_EMIT    = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [3:0] after_bar;

	// After a bar height: the frame's final band goes on to the range update
	assign after_bar = sts.last ? ST_RNG : ST_EMIT;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL_HI;
				end
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_FREQ;
			end
			ST_FREQ: begin
				cmd.freq = 1'b1;
				state_d  = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.close) begin
					state_d = ST_BAR;
				end else if (sts.frame_end) begin
					state_d = ST_FE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FE: begin
				cmd.fin_src = 1'b1;
				state_d     = ST_BAR;
			end
			ST_BAR: begin
				cmd.bar_prep = 1'b1;
				state_d      = sts.bar_direct ? after_bar : ST_BAR_CHK;
			end
			ST_BAR_CHK: begin
				cmd.bar_chk = 1'b1;
				state_d     = sts.bar_ovf ? after_bar : ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.bar_take = 1'b1;
					state_d      = after_bar;
				end
			end
			ST_RNG: begin
				cmd.rng_prep = 1'b1;
				state_d      = sts.rng_keep ? ST_EMIT : ST_RNG_GO;
			end
			ST_RNG_GO: begin
				cmd.rng_start = 1'b1;
				state_d       = ST_RNG_DIV;
			end
			ST_RNG_DIV: begin
				cmd.rng_take = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last) begin
						state_d = ST_IDLE;
					end else if (sts.frame_end) begin
						state_d = ST_FE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// One bin in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("olm_ctrl: second word taken while a bin is in flight");

	// Divider results arrive only while a bar divide is awaited
	a_div_expected: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_DIV))
		else $error("olm_ctrl: divider finished outside a divide wait");

	// The final word of a frame returns the sequencer to idle
	a_frame_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.last) |=> in_ready)
		else $error("olm_ctrl: not idle after the final word of a frame");

endmodule

`default_nettype wire

// File: hdl/olm_dp.sv
// Datapath for the level meter: magnitude estimate, band tracking, bar and range math.
// Depends on olm_pkg and olm_div; driven by olm_ctrl through command and status structs.
`default_nettype none

module olm_dp #(
	parameter int BAND_COUNT = olm_pkg::BAND_COUNT_DEF,
	parameter int BAR_ROWS   = olm_pkg::BAR_ROWS_DEF,
	parameter int FFT_SIZE   = olm_pkg::FFT_SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  olm_pkg::ctrl_cmd_t                 cmd,
	output olm_pkg::dp_sts_t                   sts,
	input  logic signed [olm_pkg::IN_W-1:0]    bin_real,
	input  logic signed [olm_pkg::IN_W-1:0]    bin_imag,
	input  logic                               frame_end,
	input  logic                               cfg_valid,
	input  logic [olm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [olm_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [olm_pkg::BAND_W-1:0]         band_number,
	output logic [olm_pkg::BAR_W-1:0]          bar_height,
	output logic [olm_pkg::MAG_W-1:0]          full_scale,
	output logic [olm_pkg::MAG_W-1:0]          frame_peak,
	output logic                               last_of_frame
);
	import olm_pkg::*;

	localparam int CNT_W  = $clog2(FFT_SIZE / 2);
	localparam int MAG_SH = $clog2(FFT_SIZE) - 1 + 16;
	localparam int RW     = $clog2(BAR_ROWS + 2);
	localparam int QB     = $clog2(BAR_ROWS + 1);
	localparam int NUM_W  = MAG_W + RW;
	localparam int PROD_W = 16 + IN_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int FW     = CNT_W + 16;
	localparam int EW     = 32;
	localparam int CW     = MAG_W + QR - 1;
	// Reciprocal of the row count, exact for every scaled range below 2^NUM_W
	localparam int RCP_SH = NUM_W + $clog2(BAR_ROWS);
	localparam int RCP_W  = NUM_W + 1;
	localparam int RP_W   = NUM_W + RCP_W;
	localparam logic [RCP_W-1:0]  RCP      = RCP_W'((64'd1 << RCP_SH) / BAR_ROWS + 1);
	localparam logic [CNT_W-1:0]  BIN_MAX  = CNT_W'(FFT_SIZE / 2 - 1);
	localparam logic [BAND_W-1:0] BAND_TOP = BAND_W'(BAND_COUNT - 1);

	// Configuration registers
	logic [CFG_W-1:0] noise_q;
	logic [CFG_W-1:0] rfloor_q;
	logic [CFG_W-1:0] spacing_q;

	// Working registers
	logic [IN_W-1:0]   hi_q;
	logic [IN_W-1:0]   lo_q;
	logic              fe_q;
	logic [ACC_W-1:0]  acc_q;
	logic [MAG_W-1:0]  mag_q;
	logic [FW-1:0]     freq_q;
	logic [MAG_W-1:0]  bsrc_q;
	logic [BAND_W-1:0] rep_band_q;
	logic              last_q;
	logic [QB-1:0]     bar_q;
	logic              grow_q;
	logic [QR-1:0]     rng_quo_q;

	// Frame state
	logic [CNT_W-1:0]  bin_cnt_q;
	logic [BAND_W-1:0] band_q;
	logic [MAG_W-1:0]  band_peak_q;
	logic [MAG_W-1:0]  peak_q;
	logic [MAG_W-1:0]  range_q;

	// Output register
	logic              out_valid_q;
	logic [BAND_W-1:0] band_o_q;
	logic [BAR_W-1:0]  bar_o_q;
	logic [MAG_W-1:0]  full_o_q;
	logic [MAG_W-1:0]  peak_o_q;
	logic              last_o_q;

	// Combinational
	logic [IN_W-1:0]        re_u;
	logic [IN_W-1:0]        im_u;
	logic [IN_W-1:0]        abs_re;
	logic [IN_W-1:0]        abs_im;
	logic [15:0]            mul_a;
	logic [IN_W-1:0]        mul_b;
	logic [PROD_W-1:0]      prod;
	logic [ACC_W-1:0]       mag_full;
	logic [MAG_W-1:0]       mag_sat;
	logic [MAG_W-1:0]       noise_ext;
	logic [MAG_W-1:0]       fl_ext;
	logic [EW-1:0]          edge_hz;
	logic                   close;
	logic                   grow;
	logic                   shrink;
	logic [MAG_W+1:0]       range_x3;
	logic                   bar_zero;
	logic                   bar_full;
	logic [NUM_W-1:0]       div_num;
	logic [MAG_W-1:0]       bar_den;
	logic                   bar_ovf;
	logic                   div_go;
	logic                   div_busy;
	logic                   div_done;
	logic [QR-1:0]          div_quo;
	logic [QB-1:0]          bar_div;
	logic [RP_W-1:0]        rcp_prod;
	logic [MAG_W-1:0]       rng_new;
	logic [BAR_W+QB-1:0]    bar_ext;
	logic                   out_free;

	// Absolute parts of the bin
	assign re_u   = bin_real;
	assign im_u   = bin_imag;
	assign abs_re = re_u[IN_W-1] ? (~re_u + IN_W'(1)) : re_u;
	assign abs_im = im_u[IN_W-1] ? (~im_u + IN_W'(1)) : im_u;

	assign noise_ext = MAG_W'(noise_q);
	assign fl_ext    = (rfloor_q == '0) ? MAG_W'(1) : MAG_W'(rfloor_q);

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.mul_hi) begin
			mul_a = ALPHA_Q16;
			mul_b = hi_q;
		end else if (cmd.mul_lo) begin
			mul_a = BETA_Q16;
			mul_b = lo_q;
		end else if (cmd.freq) begin
			mul_a = spacing_q;
			mul_b = IN_W'(bin_cnt_q);
		end else if (cmd.bar_prep) begin
			mul_a = 16'(BAR_ROWS);
			mul_b = IN_W'(bsrc_q - noise_ext);
		end else if (cmd.rng_prep) begin
			mul_a = grow ? 16'(BAR_ROWS + 1) : 16'(BAR_ROWS - 1);
			mul_b = IN_W'(range_q);
		end
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Scale by 2/N and drop the fraction, saturate to the magnitude width
	assign mag_full = acc_q >> MAG_SH;
	assign mag_sat  = (mag_full > ACC_W'(MAG_MAX)) ? MAG_MAX : mag_full[MAG_W-1:0];

	// Band edge in sixteenths of a hertz: 2^(band+5) Hz
	assign edge_hz = EW'(1) << ({1'b0, band_q} + 5'd9);
	assign close   = (band_q < BAND_TOP) && (EW'(freq_q) > edge_hz);

	// Range grow and shrink decisions
	assign range_x3 = ({2'b00, range_q} << 1) + {2'b00, range_q};
	assign grow     = {peak_q, 2'b00} > range_x3;
	assign shrink   = {1'b0, peak_q, 1'b0} < {2'b00, range_q};

	// Bar early outs
	assign bar_zero = bsrc_q <= noise_ext;
	assign bar_full = range_q <= noise_ext;

	// Divider operands
	assign div_num = acc_q[NUM_W-1:0];
	assign bar_den = range_q - noise_ext;
	assign bar_ovf = CW'(div_num) >= (CW'(bar_den) << QB);
	assign div_go  = cmd.bar_chk && !bar_ovf;

	olm_div #(
		.NUM_W (NUM_W),
		.QB    (QB)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (div_num),
		.den    (bar_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Scale the range by a multiply with the reciprocal of the row count
	assign rcp_prod = RP_W'(div_num) * RP_W'(RCP);

	// Saturate the bar quotient, clamp or floor the new range
	assign bar_div = (div_quo > QR'(BAR_ROWS)) ? QB'(BAR_ROWS) : div_quo[QB-1:0];

	always_comb begin
		if (grow_q) begin
			rng_new = (rng_quo_q > QR'(MAG_MAX)) ? MAG_MAX : rng_quo_q[MAG_W-1:0];
		end else begin
			rng_new = (rng_quo_q[MAG_W-1:0] < fl_ext) ? fl_ext : rng_quo_q[MAG_W-1:0];
		end
	end

	assign bar_ext  = {BAR_W'(0), bar_q};
	assign out_free = !out_valid_q || out_ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q   <= NOISE_FLOOR_RST;
			rfloor_q  <= RANGE_FLOOR_RST;
			spacing_q <= BIN_SPACING_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NOISE_FLOOR: noise_q   <= cfg_data;
				CFG_RANGE_FLOOR: rfloor_q  <= cfg_data;
				CFG_BIN_SPACING: spacing_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Capture the bin, accumulate the estimate, compute magnitude and frequency
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hi_q <= (abs_re > abs_im) ? abs_re : abs_im;
			lo_q <= (abs_re > abs_im) ? abs_im : abs_re;
			fe_q <= frame_end;
		end
		if (cmd.mul_hi || cmd.bar_prep || cmd.rng_prep) begin
			acc_q <= ACC_W'(prod);
		end else if (cmd.mul_lo) begin
			acc_q <= acc_q + ACC_W'(prod);
		end
		if (cmd.freq) begin
			freq_q <= prod[FW-1:0];
			mag_q  <= mag_sat;
		end
		if (cmd.rng_prep) begin
			grow_q <= grow;
		end
		if (cmd.rng_start) begin
			rng_quo_q <= rcp_prod[RCP_SH +: QR];
		end
	end

	// Select the band to report and settle its bar height
	always_ff @(posedge clk) begin
		if (cmd.eval && close) begin
			bsrc_q     <= band_peak_q;
			rep_band_q <= band_q;
		end else if (cmd.fin_src) begin
			bsrc_q     <= band_peak_q;
			rep_band_q <= band_q;
		end
		if (cmd.bar_prep && bar_zero) begin
			bar_q <= '0;
		end else if (cmd.bar_prep && bar_full) begin
			bar_q <= QB'(BAR_ROWS);
		end else if (cmd.bar_chk && bar_ovf) begin
			bar_q <= QB'(BAR_ROWS);
		end else if (cmd.bar_take) begin
			bar_q <= bar_div;
		end
	end

	// Frame state: bin count, band, peaks and range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q   <= '0;
			band_q      <= '0;
			band_peak_q <= '0;
			peak_q      <= '0;
			range_q     <= AUTO_RANGE_RST;
			last_q      <= 1'b0;
		end else begin
			if (cmd.eval) begin
				last_q <= 1'b0;
				if (mag_q > peak_q) begin
					peak_q <= mag_q;
				end
				if (close) begin
					band_q      <= band_q + BAND_W'(1);
					band_peak_q <= mag_q;
				end else if (mag_q > band_peak_q) begin
					band_peak_q <= mag_q;
				end
				if (!fe_q && bin_cnt_q < BIN_MAX) begin
					bin_cnt_q <= bin_cnt_q + CNT_W'(1);
				end
			end
			if (cmd.fin_src) begin
				last_q <= 1'b1;
			end
			if (cmd.rng_take) begin
				range_q <= rng_new;
			end
			// Drop frame state but the range after its final word
			if (cmd.emit && last_q) begin
				bin_cnt_q   <= '0;
				band_q      <= '0;
				band_peak_q <= '0;
				peak_q      <= '0;
				last_q      <= 1'b0;
			end
		end
	end

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			band_o_q <= rep_band_q;
			bar_o_q  <= bar_ext[BAR_W-1:0];
			full_o_q <= range_q;
			peak_o_q <= peak_q;
			last_o_q <= last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign band_number   = band_o_q;
	assign bar_height    = bar_o_q;
	assign full_scale    = full_o_q;
	assign frame_peak    = peak_o_q;
	assign last_of_frame = last_o_q;

	// Status to the controller
	always_comb begin
		sts            = '0;
		sts.close      = close;
		sts.frame_end  = fe_q;
		sts.last       = last_q;
		sts.bar_direct = bar_zero || bar_full;
		sts.bar_ovf    = bar_ovf;
		sts.rng_keep   = !grow && !shrink;
		sts.div_done   = div_done;
		sts.out_free   = out_free;
	end

	// A divide never restarts while one is running
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> !div_busy)
		else $error("olm_dp: divider started while busy");

	// The final word of a frame clears the peak, band and bin count
	a_frame_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && last_q) |=> (peak_q == '0 && band_q == '0 && bin_cnt_q == '0))
		else $error("olm_dp: frame state not cleared after the final word");

	// A shrunk range never falls below its floor
	a_rng_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rng_take && !grow_q) |=> (range_q >= fl_ext))
		else $error("olm_dp: range below floor after a shrink");

endmodule

`default_nettype wire

// File: hdl/octave_band_level_meter.sv
// Each bin passes the multiply, frequency and evaluation states; one that closes a band adds
// the bar work before its word is registered: prepare, then check and divide unless the bar
// settles early. The divider yields one quotient bit per cycle, QB = clog2(BAR_ROWS+1) bits,
// 4 by default. The frame's last bin adds a final source step, the same bar work and the range
// update. Throughput: one bin at a time; outputs sit in a register so a stalled consumer does not
// block the next bin until a word must be written. Reset initialises control and frame state.
`default_nettype none

module octave_band_level_meter #(
	parameter int BAND_COUNT = olm_pkg::BAND_COUNT_DEF,
	parameter int BAR_ROWS   = olm_pkg::BAR_ROWS_DEF,
	parameter int FFT_SIZE   = olm_pkg::FFT_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [olm_pkg::IN_W-1:0] bin_real,
	input  logic signed [olm_pkg::IN_W-1:0] bin_imag,
	input  logic                            frame_end,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [olm_pkg::BAND_W-1:0]      band_number,
	output logic [olm_pkg::BAR_W-1:0]       bar_height,
	output logic [olm_pkg::MAG_W-1:0]       full_scale,
	output logic [olm_pkg::MAG_W-1:0]       frame_peak,
	output logic                            last_of_frame,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [olm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [olm_pkg::CFG_W-1:0]       cfg_data
);
	import olm_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// Registers take a word in any cycle
	assign cfg_ready = 1'b1;

	olm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	olm_dp #(
		.BAND_COUNT (BAND_COUNT),
		.BAR_ROWS   (BAR_ROWS),
		.FFT_SIZE   (FFT_SIZE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.bin_real      (bin_real),
		.bin_imag      (bin_imag),
		.frame_end     (frame_end),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.band_number   (band_number),
		.bar_height    (bar_height),
		.full_scale    (full_scale),
		.frame_peak    (frame_peak),
		.last_of_frame (last_of_frame)
	);

endmodule

`default_nettype wire
